FILE: design/jkse_pkg.sv
// Shared types and constants of the JSON key string-value extractor.
`timescale 1ns / 1ps
`default_nettype none
package jkse_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned GroupBytes = 3;

  // Register indexes of the configuration port.
  localparam logic [1:0] CfgKeyFirst  = 2'd0;
  localparam logic [1:0] CfgKeySecond = 2'd1;
  localparam logic [1:0] CfgKeyLength = 2'd2;
  localparam logic [1:0] CfgBufSize   = 2'd3;

  // Results caused by one text byte: up to three value bytes, then maybe a status.
  typedef struct packed {
    logic [GroupBytes-1:0][7:0] bytes;
    logic [1:0]                 count;
    logic                       status;
    logic                       failed;
  } group_t;

endpackage
`default_nettype wire

FILE: design/jkse_front.sv
// Parser front end: accepts text bytes and turns each into a group of results.
`timescale 1ns / 1ps
`default_nettype none
module jkse_front #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic [127:0]      key_i,
  input  wire logic [4:0]        key_length_i,
  input  wire logic [15:0]       buffer_size_i,
  output      logic              push_o,
  output      jkse_pkg::group_t  group_o,
  input  wire logic              full_i
);
  import jkse_pkg::*;

  typedef enum logic [2:0] {
    PhSeek, PhKey, PhColon, PhQuote, PhValue, PhEsc, PhHex, PhDone
  } phase_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [4:0] KeyMax  = 5'(MAX_KEY_BYTES);

  phase_e      phase_q, phase_d;
  logic [4:0]  kpos_q, kpos_d;
  logic        kmis_q, kmis_d;
  logic [15:0] vcount_q, vcount_d;
  logic [15:0] cp_q, cp_d;
  logic [1:0]  hexn_q, hexn_d;

  logic [15:0][7:0] key_arr;
  logic [4:0]  klen;
  logic [7:0]  c;
  logic        is_ws;
  logic [4:0]  hex;
  logic [1:0]  grp_n;
  logic [GroupBytes-1:0][7:0] grp;
  logic [17:0] need;
  logic        fin;
  logic        fin_fail;
  logic        accept;

  function automatic logic [4:0] hex_val(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h10;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b0, 4'(ch - 8'h30)};
    else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b0, 4'(ch - 8'h57)};
    else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b0, 4'(ch - 8'h37)};
    return r;
  endfunction

  assign key_arr    = key_i;
  assign klen       = (key_length_i > KeyMax) ? KeyMax : key_length_i;
  assign c          = text_byte_i;
  assign is_ws      = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  assign hex        = hex_val(c);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign need       = {2'b00, vcount_q} + {16'd0, grp_n} + 18'd1;

  always_comb begin
    phase_d  = phase_q;
    kpos_d   = kpos_q;
    kmis_d   = kmis_q;
    vcount_d = vcount_q;
    cp_d     = cp_q;
    hexn_d   = hexn_q;
    grp_n    = 2'd0;
    grp      = '0;
    fin      = 1'b0;
    fin_fail = 1'b1;
    case (phase_q)
      PhSeek: begin
        if (c == 8'h00) fin = 1'b1;
        else if (c == ChQuote) begin
          phase_d = PhKey;
          kpos_d  = 5'd0;
          kmis_d  = 1'b0;
        end
      end
      PhKey: begin
        if (c == 8'h00) fin = 1'b1;
        else if (c == ChQuote) begin
          phase_d = (!kmis_q && kpos_q == klen) ? PhColon : PhSeek;
        end else if (!kmis_q && kpos_q < klen && key_arr[kpos_q[3:0]] == c) begin
          kpos_d = kpos_q + 5'd1;
        end else begin
          kmis_d = 1'b1;
        end
      end
      PhColon: begin
        if (c == ChColon) phase_d = PhQuote;
        else if (!is_ws) fin = 1'b1;
      end
      PhQuote: begin
        if (c == ChQuote) begin
          phase_d  = PhValue;
          vcount_d = 16'd0;
        end else if (!is_ws) fin = 1'b1;
      end
      PhValue: begin
        if (c == 8'h00) fin = 1'b1;
        else if (c == ChQuote) begin
          fin      = 1'b1;
          fin_fail = (buffer_size_i == 16'd0);
        end else if (c == ChBack) phase_d = PhEsc;
        else begin
          grp_n  = 2'd1;
          grp[0] = c;
        end
      end
      PhEsc: begin
        phase_d = PhValue;
        grp_n   = 2'd1;
        case (c)
          ChQuote, ChBack, ChSlash: grp[0] = c;
          8'h62: grp[0] = 8'h08;
          8'h66: grp[0] = 8'h0C;
          8'h6E: grp[0] = 8'h0A;
          8'h72: grp[0] = 8'h0D;
          8'h74: grp[0] = 8'h09;
          8'h75: begin
            grp_n   = 2'd0;
            phase_d = PhHex;
            cp_d    = 16'd0;
            hexn_d  = 2'd0;
          end
          default: begin
            grp_n = 2'd0;
            fin   = 1'b1;
          end
        endcase
      end
      PhHex: begin
        if (hex[4]) fin = 1'b1;
        else begin
          cp_d = {cp_q[11:0], hex[3:0]};
          if (hexn_q != 2'd3) hexn_d = hexn_q + 2'd1;
          else begin
            hexn_d  = 2'd0;
            phase_d = PhValue;
            if (cp_d < 16'h0080) begin
              grp_n  = 2'd1;
              grp[0] = cp_d[7:0];
            end else if (cp_d < 16'h0800) begin
              grp_n  = 2'd2;
              grp[0] = 8'hC0 | {3'b000, cp_d[10:6]};
              grp[1] = 8'h80 | {2'b00, cp_d[5:0]};
            end else begin
              grp_n  = 2'd3;
              grp[0] = 8'hE0 | {4'h0, cp_d[15:12]};
              grp[1] = 8'h80 | {2'b00, cp_d[11:6]};
              grp[2] = 8'h80 | {2'b00, cp_d[5:0]};
            end
          end
        end
      end
      default: ;
    endcase

    group_o = '0;
    if (grp_n != 2'd0) begin
      if (need > {2'b00, buffer_size_i}) begin
        fin      = 1'b1;
        fin_fail = 1'b1;
      end else begin
        group_o.bytes = grp;
        group_o.count = grp_n;
        vcount_d      = vcount_q + {14'd0, grp_n};
      end
    end
    if (fin) begin
      phase_d        = PhDone;
      group_o.status = 1'b1;
      group_o.failed = fin_fail;
    end

    if (last_byte_i) begin
      if (phase_d != PhDone) begin
        group_o.status = 1'b1;
        group_o.failed = 1'b1;
      end
      phase_d  = PhSeek;
      kpos_d   = 5'd0;
      kmis_d   = 1'b0;
      vcount_d = 16'd0;
      cp_d     = 16'd0;
      hexn_d   = 2'd0;
    end
  end

  assign push_o = accept && (group_o.status || group_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSeek;
      kpos_q   <= 5'd0;
      kmis_q   <= 1'b0;
      vcount_q <= 16'd0;
      cp_q     <= 16'd0;
      hexn_q   <= 2'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      kpos_q   <= kpos_d;
      kmis_q   <= kmis_d;
      vcount_q <= vcount_d;
      cp_q     <= cp_d;
      hexn_q   <= hexn_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/jkse_queue.sv
// Short queue of result groups between the parser and the output serializer.
`timescale 1ns / 1ps
`default_nettype none
module jkse_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire jkse_pkg::group_t  push_group_i,
  output      logic              full_o,
  input  wire logic              pop_i,
  output      jkse_pkg::group_t  head_o,
  output      logic              empty_o
);
  import jkse_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  group_t          entries_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wptr_q] <= push_group_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PtrW'(1);
      if (pop_i) rptr_q <= rptr_q + PtrW'(1);
      if (push_i && !pop_i) count_q <= count_q + (PtrW+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PtrW+1)'(1);
    end
  end

endmodule
`default_nettype wire

FILE: design/jkse_back.sv
// Output serializer: hands out the results of each queued group one per cycle while the output is ready.
`timescale 1ns / 1ps
`default_nettype none
module jkse_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire jkse_pkg::group_t  head_i,
  input  wire logic              empty_i,
  output      logic              pop_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [7:0]        value_byte_o,
  output      logic              is_status_o,
  output      logic              failed_o,
  output      logic              last_of_run_o
);
  import jkse_pkg::*;

  logic [1:0] idx_q;
  logic [2:0] total;
  logic       is_value;

  assign total       = {1'b0, head_i.count} + {2'b00, head_i.status};
  assign is_value    = (idx_q < head_i.count);
  assign out_valid_o = !empty_i;

  always_comb begin
    value_byte_o = 8'h00;
    if (is_value) begin
      case (idx_q)
        2'd0:    value_byte_o = head_i.bytes[0];
        2'd1:    value_byte_o = head_i.bytes[1];
        2'd2:    value_byte_o = head_i.bytes[2];
        default: value_byte_o = 8'h00;
      endcase
    end
  end

  assign is_status_o   = !is_value;
  assign failed_o      = !is_value && head_i.failed;
  assign last_of_run_o = ({1'b0, idx_q} == total - 3'd1);
  assign pop_o         = out_valid_o && out_ready_i && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (out_valid_o && out_ready_i) begin
      idx_q <= last_of_run_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: design/json_key_string_value_extractor.sv
// Top level of the JSON key string-value extractor: registers and the three stages.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tdata text_byte, tlast last_byte
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata value_byte, tuser status, tlast
//   cfg       in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// The parser takes one text byte per cycle while the result queue has room.
// Each byte yields up to four results, delivered one per cycle by the serializer while
// the output is ready; the input stalls only when groups of several results arrive
// faster than they drain. Reset clears the parse state and the queue; the key registers
// reset to zero. A stalled output fills the four-entry queue and then stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module json_key_string_value_extractor #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] value_byte
  output      logic [1:0]  m_axis_tuser,   // [0] is_status, [1] failed
  output      logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import jkse_pkg::*;

  logic [63:0] key_first_q, key_second_q;
  logic [4:0]  key_len_q;
  logic [15:0] buf_size_q;

  logic   push, full, pop, empty;
  group_t push_group, head;
  logic   is_status, failed;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= 64'd0;
      key_second_q <= 64'd0;
      key_len_q    <= 5'd0;
      buf_size_q   <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgKeyFirst:  key_first_q  <= cfg_data_i;
        CfgKeySecond: key_second_q <= cfg_data_i;
        CfgKeyLength: key_len_q    <= cfg_data_i[4:0];
        CfgBufSize:   buf_size_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  jkse_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .text_byte_i  (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .key_i        ({key_second_q, key_first_q}),
    .key_length_i (key_len_q),
    .buffer_size_i(buf_size_q),
    .push_o       (push),
    .group_o      (push_group),
    .full_i       (full)
  );

  jkse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_group_i(push_group),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  jkse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .value_byte_o (m_axis_tdata),
    .is_status_o  (is_status),
    .failed_o     (failed),
    .last_of_run_o(m_axis_tlast)
  );

  assign m_axis_tuser = {failed, is_status};

endmodule
`default_nettype wire

FILE: tb/tb_json_key_string_value_extractor.sv
// Self-checking testbench of the JSON key string-value extractor, directed table then random docs.
`timescale 1ns / 1ps
module tb_json_key_string_value_extractor;
  import jkse_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned KeyMax      = 16;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [63:0] EscChars = {8'h74, 8'h72, 8'h6E, 8'h66, 8'h62, ChSlash, ChBslash, ChQuote};

  typedef enum logic [2:0] {
    PhSeek, PhKey, PhColon, PhQuote, PhValue, PhEsc, PhHex, PhDone
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       failed;
    logic       last;
  } result_t;

  typedef struct {
    logic        is_reg;
    logic [1:0]  index;
    logic [63:0] value;
    logic [7:0]  text;
    logic        tlast;
    logic        typed;
    logic        has_res;
    result_t     res;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgKeyFirst;
  logic [63:0] cfg_data_i = 64'd0;

  // Typed expectation that travels with the request on the input side.
  logic        row_typed = 1'b0;
  logic        row_has_res = 1'b0;
  result_t     row_res = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  logic [63:0] key_lo_cfg = 64'd0;
  logic [63:0] key_hi_cfg = 64'd0;
  logic [4:0]  key_len_cfg = 5'd0;
  logic [15:0] buf_size_cfg = 16'd1;

  phase_e      phase;
  logic [4:0]  key_pos;
  logic        key_miss;
  logic [15:0] value_cnt;
  logic [15:0] code_pt;
  logic [1:0]  hex_seen;

  result_t     step_out[$];
  result_t     decoded_q[$];

  json_key_string_value_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void clear_parse();
    phase = PhSeek;
    key_pos = 5'd0;
    key_miss = 1'b0;
    value_cnt = 16'd0;
    code_pt = 16'd0;
    hex_seen = 2'd0;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic st, input logic fl);
    result_t r;
    r = '{data: b, status: st, failed: fl, last: 1'b0};
    if (step_out.size() < 4) step_out.push_back(r);
  endfunction

  function automatic void close_doc(input logic fl);
    add_result(8'h00, 1'b1, fl);
    phase = PhDone;
  endfunction

  function automatic void emit_group(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input int n);
    if (int'(value_cnt) + n + 1 > int'(buf_size_cfg)) begin
      close_doc(1'b1);
    end else begin
      add_result(b0, 1'b0, 1'b0);
      if (n > 1) add_result(b1, 1'b0, 1'b0);
      if (n > 2) add_result(b2, 1'b0, 1'b0);
      value_cnt = value_cnt + 16'(n);
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChCr;
  endfunction

  function automatic void decode_text_byte(input logic [7:0] c, input logic lst);
    logic [4:0] klen;
    logic [3:0] kp;
    logic [7:0] kb;
    logic [3:0] nib;
    logic       nib_ok;
    result_t    r;
    step_out.delete();
    klen = (key_len_cfg > KeyMax) ? 5'(KeyMax) : key_len_cfg;
    kp = key_pos[3:0];
    kb = kp[3] ? key_hi_cfg[kp[2:0]*8 +: 8] : key_lo_cfg[kp[2:0]*8 +: 8];
    nib_ok = 1'b1;
    nib = 4'd0;
    if (c >= "0" && c <= "9") nib = 4'(c - "0");
    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
    else nib_ok = 1'b0;
    case (phase)
      PhSeek: begin
        if (c == ChNul) begin
          close_doc(1'b1);
        end else if (c == ChQuote) begin
          phase = PhKey;
          key_pos = 5'd0;
          key_miss = 1'b0;
        end
      end
      PhKey: begin
        if (c == ChNul) close_doc(1'b1);
        else if (c == ChQuote) phase = (!key_miss && key_pos == klen) ? PhColon : PhSeek;
        else if (!key_miss && key_pos < klen && kb == c) key_pos = key_pos + 5'd1;
        else key_miss = 1'b1;
      end
      PhColon: begin
        if (c == ChColon) phase = PhQuote;
        else if (!is_blank(c)) close_doc(1'b1);
      end
      PhQuote: begin
        if (c == ChQuote) begin
          phase = PhValue;
          value_cnt = 16'd0;
        end else if (!is_blank(c)) begin
          close_doc(1'b1);
        end
      end
      PhValue: begin
        if (c == ChNul) close_doc(1'b1);
        else if (c == ChQuote) close_doc(buf_size_cfg == 16'd0);
        else if (c == ChBslash) phase = PhEsc;
        else emit_group(c, 8'h00, 8'h00, 1);
      end
      PhEsc: begin
        phase = PhValue;
        case (c)
          ChQuote, ChBslash, ChSlash: emit_group(c, 8'h00, 8'h00, 1);
          "b": emit_group(8'h08, 8'h00, 8'h00, 1);
          "f": emit_group(8'h0C, 8'h00, 8'h00, 1);
          "n": emit_group(8'h0A, 8'h00, 8'h00, 1);
          "r": emit_group(8'h0D, 8'h00, 8'h00, 1);
          "t": emit_group(8'h09, 8'h00, 8'h00, 1);
          "u": begin
            phase = PhHex;
            code_pt = 16'd0;
            hex_seen = 2'd0;
          end
          default: close_doc(1'b1);
        endcase
      end
      PhHex: begin
        if (!nib_ok) begin
          close_doc(1'b1);
        end else begin
          code_pt = {code_pt[11:0], nib};
          if (hex_seen < 2'd3) begin
            hex_seen = hex_seen + 2'd1;
          end else begin
            hex_seen = 2'd0;
            phase = PhValue;
            if (code_pt < 16'h0080) begin
              emit_group(code_pt[7:0], 8'h00, 8'h00, 1);
            end else if (code_pt < 16'h0800) begin
              emit_group({3'b110, code_pt[10:6]}, {2'b10, code_pt[5:0]}, 8'h00, 2);
            end else begin
              emit_group({4'hE, code_pt[15:12]}, {2'b10, code_pt[11:6]},
                         {2'b10, code_pt[5:0]}, 3);
            end
          end
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (phase != PhDone) close_doc(1'b1);
      clear_parse();
    end
    if (step_out.size() != 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgKeyFirst:  key_lo_cfg = cfg_data_i;
          CfgKeySecond: key_hi_cfg = cfg_data_i;
          CfgKeyLength: key_len_cfg = cfg_data_i[4:0];
          default:      buf_size_cfg = cfg_data_i[15:0];
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_text_byte(s_axis_tdata, s_axis_tlast);
        if (row_typed) begin
          if (row_has_res) decoded_q.push_back(row_res);
        end else begin
          foreach (step_out[k]) decoded_q.push_back(step_out[k]);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, value_byte", m_axis_tdata, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata !== want.data) report_mismatch("value_byte", m_axis_tdata, want.data);
          if (m_axis_tuser[0] !== want.status) begin
            report_mismatch("is_status", 8'(m_axis_tuser[0]), 8'(want.status));
          end
          if (m_axis_tuser[1] !== want.failed) begin
            report_mismatch("failed", 8'(m_axis_tuser[1]), 8'(want.failed));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("last_of_run", 8'(m_axis_tlast), 8'(want.last));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input logic has_res, input result_t res);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= lst;
    row_typed <= typed;
    row_has_res <= has_res;
    row_res <= res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic plan_row_t text_row(input logic [7:0] b, input logic l);
    plan_row_t p;
    p = '{is_reg: 1'b0, index: CfgKeyFirst, value: 64'd0, text: b, tlast: l,
          typed: 1'b0, has_res: 1'b0, res: '0};
    return p;
  endfunction

  function automatic plan_row_t quiet_row(input logic [7:0] b, input logic l);
    plan_row_t p;
    p = text_row(b, l);
    p.typed = 1'b1;
    return p;
  endfunction

  function automatic plan_row_t status_row(input logic [7:0] b, input logic l, input logic fl);
    plan_row_t p;
    p = quiet_row(b, l);
    p.has_res = 1'b1;
    p.res = '{data: 8'h00, status: 1'b1, failed: fl, last: 1'b1};
    return p;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [63:0] val);
    plan_row_t p;
    p = text_row(8'h00, 1'b0);
    p.is_reg = 1'b1;
    p.index = idx;
    p.value = val;
    return p;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v - 10);
  endfunction

  initial begin : stimulus
    plan_row_t   plan[$];
    logic [7:0]  doc_q[$];
    logic [7:0]  key_bytes[16];
    logic [7:0]  ch;
    logic [4:0]  key_len;
    logic [15:0] buf_sz;
    logic [15:0] cp;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    int          n;
    int          kind;
    int          trail;
    int          klen_eff;
    int          items;
    int          docs;

    clear_parse();

    // Power-on settings: empty key, room for the terminator only.
    plan.push_back(status_row(ChNul, 1'b0, 1'b1));
    plan.push_back(quiet_row(8'hFF, 1'b1));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row(ChColon, 1'b0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(status_row(ChQuote, 1'b1, 1'b0));
    // One-byte key, largest buffer, escapes and the widest UTF-8 group.
    plan.push_back(reg_row(CfgKeyFirst, 64'hFFFF_FFFF_FFFF_FF6B));
    plan.push_back(reg_row(CfgKeySecond, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(reg_row(CfgKeyLength, 64'd1));
    plan.push_back(reg_row(CfgBufSize, 64'h0000_0000_0000_FFFF));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row("k", 1'b0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row(ChColon, 1'b0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row(ChBslash, 1'b0));
    plan.push_back(text_row("u", 1'b0));
    plan.push_back(text_row("F", 1'b0));
    plan.push_back(text_row("f", 1'b0));
    plan.push_back(text_row("f", 1'b0));
    plan.push_back(text_row("F", 1'b0));
    plan.push_back(text_row(ChBslash, 1'b0));
    plan.push_back(status_row("q", 1'b0, 1'b1));
    plan.push_back(quiet_row("x", 1'b1));
    // Oversized key length and a zero buffer.
    plan.push_back(reg_row(CfgKeyLength, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(reg_row(CfgBufSize, 64'd0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(status_row(ChQuote, 1'b1, 1'b1));
    plan.push_back(reg_row(CfgKeyLength, 64'd0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(text_row(ChColon, 1'b0));
    plan.push_back(text_row(ChQuote, 1'b0));
    plan.push_back(status_row(ChQuote, 1'b1, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].index, plan[i].value);
      end else begin
        send_byte(plan[i].text, plan[i].tlast, plan[i].typed, plan[i].has_res, plan[i].res);
      end
    end

    items = 0;
    docs = 0;
    key_len = 5'd0;
    while (items < RandomItems) begin
      if (docs % 3 == 0) begin
        for (int k = 0; k < 16; k++) begin
          do ch = 8'($urandom_range(1, 255)); while (ch == ChQuote);
          key_bytes[k] = ch;
        end
        for (int k = 0; k < 8; k++) begin
          key_lo[k*8 +: 8] = key_bytes[k];
          key_hi[k*8 +: 8] = key_bytes[k+8];
        end
        case ($urandom_range(9))
          0: key_len = 5'd0;
          1: key_len = 5'd16;
          2: key_len = 5'($urandom_range(17, 31));
          default: key_len = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(9))
          0: buf_sz = 16'd0;
          1: buf_sz = 16'd1;
          2: buf_sz = 16'd2;
          3: buf_sz = 16'hFFFF;
          4, 5: buf_sz = 16'($urandom_range(3, 65534));
          default: buf_sz = 16'($urandom_range(3, 10));
        endcase
        write_reg(CfgKeyFirst, key_lo);
        write_reg(CfgKeySecond, key_hi);
        write_reg(CfgKeyLength, {$urandom, 27'($urandom), key_len});
        write_reg(CfgBufSize, {$urandom, 16'($urandom), buf_sz});
      end
      klen_eff = (key_len > KeyMax) ? KeyMax : int'(key_len);

      case ((docs / 2) % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin sender_idle_pct = 9; sink_stall_pct = 9; end
      endcase

      doc_q.delete();
      trail = 0;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 15)) doc_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) doc_q.push_back(blank_char());
        if ($urandom_range(9) < 4) begin
          doc_q.push_back(ChQuote);
          repeat ($urandom_range(1, 5)) doc_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
          doc_q.push_back(ChQuote);
          doc_q.push_back(ChColon);
          doc_q.push_back(8'h37);
          doc_q.push_back(8'h2C);
        end
        doc_q.push_back(ChQuote);
        for (int k = 0; k < klen_eff; k++) doc_q.push_back(key_bytes[k]);
        doc_q.push_back(ChQuote);
        repeat ($urandom_range(0, 2)) doc_q.push_back(blank_char());
        doc_q.push_back(ChColon);
        repeat ($urandom_range(0, 2)) doc_q.push_back(blank_char());
        doc_q.push_back(ChQuote);
        repeat ($urandom_range(0, 8)) begin
          kind = $urandom_range(99);
          if (kind < 55) begin
            do ch = 8'($urandom_range(1, 255)); while (ch == ChQuote || ch == ChBslash);
            doc_q.push_back(ch);
          end else if (kind < 75) begin
            doc_q.push_back(ChBslash);
            doc_q.push_back(EscChars[$urandom_range(7)*8 +: 8]);
          end else if (kind < 95) begin
            case ($urandom_range(2))
              0: cp = 16'($urandom_range(16'h0000, 16'h007F));
              1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
              default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            doc_q.push_back(ChBslash);
            doc_q.push_back("u");
            for (int d = 3; d >= 0; d--) doc_q.push_back(hex_char(cp[d*4 +: 4]));
          end else if (kind < 98) begin
            doc_q.push_back(ChBslash);
            doc_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
          end else begin
            doc_q.push_back(ChBslash);
            doc_q.push_back("u");
            repeat ($urandom_range(0, 3)) doc_q.push_back(hex_char(4'($urandom)));
            doc_q.push_back("g");
          end
        end
        doc_q.push_back(ChQuote);
        kind = $urandom_range(99);
        if (kind < 8) begin
          doc_q[$urandom_range(doc_q.size() - 1)] = 8'($urandom);
        end else if (kind < 13) begin
          doc_q[$urandom_range(doc_q.size() - 1)] = ChNul;
        end else if (kind < 18) begin
          n = $urandom_range(1, doc_q.size() - 1);
          while (doc_q.size() > n) void'(doc_q.pop_back());
        end else begin
          trail = $urandom_range(0, 3);
          repeat (trail) doc_q.push_back(8'($urandom));
        end
      end

      foreach (doc_q[j]) begin
        if (docs == 2 && j == doc_q.size() / 2) wait_drained();
        send_byte(doc_q[j], j == doc_q.size() - 1, 1'b0, 1'b0, '0);
      end
      items += doc_q.size() - trail;
      docs++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
